// ===== hw/rtl/tmk_pkg.sv =====
`default_nettype none

package tmk_pkg;

  // Number format and store geometry.
  localparam int DW          = 64;
  localparam int HW          = DW / 2;
  localparam int FRAC_BITS   = 48;
  localparam int MAX_ORDER   = 15;
  localparam int NSTEP       = MAX_ORDER + 1;
  localparam int COEF_DEPTH  = 2 * (MAX_ORDER + 1);
  localparam int CIDX_W      = 5;
  localparam int ORD_W       = 4;

  // Pipeline depths.
  localparam int MUL_LAT     = 4;
  localparam int STEP_LAT    = MUL_LAT + 2;
  localparam int TAIL_LAT    = 4 * MUL_LAT + 4;
  localparam int TOTAL_LAT   = NSTEP * STEP_LAT + TAIL_LAT;
  localparam int INFL_W      = $clog2(TOTAL_LAT + 1);

  // Tail stage positions (add stages between multiplier phases).
  localparam int T_P2        = MUL_LAT + 1;
  localparam int T_P4        = 2 * MUL_LAT + 2;
  localparam int T_P6        = 3 * MUL_LAT + 3;
  localparam int T_P8        = 4 * MUL_LAT + 4;

  // Divider and multiplier widths.
  localparam int NUM_W       = DW + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int SH_W        = 2 * DW - FRAC_BITS;
  localparam logic [2*DW-1:0] RND_HALF = (2*DW)'(1) << (FRAC_BITS - 1);

  // Stream widths.
  localparam int IN_BITS     = CIDX_W + 9 * DW;
  localparam int IN_DW       = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_PAD      = IN_DW - IN_BITS;
  localparam int OUT_DW      = 3 * DW;

  typedef logic signed [DW-1:0] fx_t;

  localparam fx_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_TRACK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ORDER = 2'd0,
    CFG_HXL   = 2'd1,
    CFG_HYL   = 2'd2,
    CFG_LEN   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [IN_PAD-1:0] pad;
    fx_t               velocity_ratio;
    fx_t               path_sigma;
    fx_t               energy_dev;
    fx_t               charge_ratio;
    fx_t               mom_py;
    fx_t               mom_px;
    fx_t               pos_y;
    fx_t               pos_x;
    fx_t               coef_value;
    logic [CIDX_W-1:0] coef_index;
  } in_data_t;

  typedef struct packed {
    fx_t new_sigma;
    fx_t new_py;
    fx_t new_px;
  } out_data_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t px;
    fx_t py;
    fx_t chi;
    fx_t delta;
    fx_t sigma;
    fx_t rvv;
  } part_t;

  typedef struct packed {
    logic  valid;
    part_t pt;
    fx_t   dpx;
    fx_t   dpy;
  } hn_t;

  typedef struct packed {
    logic  valid;
    part_t pt;
    fx_t   dpx;
    fx_t   dpy;
    fx_t   ex;
    fx_t   ey;
    fx_t   dhh;
    fx_t   b1l;
    fx_t   a1l;
    fx_t   hxx;
    fx_t   hyy;
    fx_t   fx;
    fx_t   fy;
    fx_t   tt;
  } tl_t;

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  function automatic fx_t sat_neg(fx_t a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tmk_mul.sv =====
`default_nettype none

// Fixed-point multiply: magnitude, four partial products, rounded sum, saturation.
module tmk_mul (
  input  logic             clk,
  input  logic             en,
  input  tmk_pkg::fx_t     a,
  input  tmk_pkg::fx_t     b,
  output tmk_pkg::fx_t     p
);

  logic [tmk_pkg::DW-1:0]     ua_w, ub_w;
  logic [tmk_pkg::DW-1:0]     ua_r, ub_r;
  logic                       neg1_r, neg2_r, neg3_r;
  logic [tmk_pkg::DW-1:0]     pp_r [0:3];
  logic [2*tmk_pkg::DW-1:0]   sum_w;
  logic [tmk_pkg::SH_W-1:0]   sh_r;
  logic                       ovf_w;
  tmk_pkg::fx_t               p_nxt, p_r;

  assign ua_w = a[tmk_pkg::DW-1] ? (~a + 1'b1) : a;
  assign ub_w = b[tmk_pkg::DW-1] ? (~b + 1'b1) : b;

  assign sum_w = {{tmk_pkg::DW{1'b0}}, pp_r[0]}
               + {{tmk_pkg::HW{1'b0}}, pp_r[1], {tmk_pkg::HW{1'b0}}}
               + {{tmk_pkg::HW{1'b0}}, pp_r[2], {tmk_pkg::HW{1'b0}}}
               + {pp_r[3], {tmk_pkg::DW{1'b0}}}
               + tmk_pkg::RND_HALF;

  always_comb begin
    if (neg3_r) begin
      ovf_w = (|sh_r[tmk_pkg::SH_W-1:tmk_pkg::DW])
            || (sh_r[tmk_pkg::DW-1] && (|sh_r[tmk_pkg::DW-2:0]));
    end else begin
      ovf_w = |sh_r[tmk_pkg::SH_W-1:tmk_pkg::DW-1];
    end
    if (ovf_w) begin
      p_nxt = neg3_r ? tmk_pkg::SMIN : tmk_pkg::SMAX;
    end else if (neg3_r) begin
      p_nxt = -sh_r[tmk_pkg::DW-1:0];
    end else begin
      p_nxt = sh_r[tmk_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r     <= ua_w;
      ub_r     <= ub_w;
      neg1_r   <= a[tmk_pkg::DW-1] ^ b[tmk_pkg::DW-1];
      pp_r[0]  <= ua_r[tmk_pkg::HW-1:0] * ub_r[tmk_pkg::HW-1:0];
      pp_r[1]  <= ua_r[tmk_pkg::HW-1:0] * ub_r[tmk_pkg::DW-1:tmk_pkg::HW];
      pp_r[2]  <= ua_r[tmk_pkg::DW-1:tmk_pkg::HW] * ub_r[tmk_pkg::HW-1:0];
      pp_r[3]  <= ua_r[tmk_pkg::DW-1:tmk_pkg::HW] * ub_r[tmk_pkg::DW-1:tmk_pkg::HW];
      neg2_r   <= neg1_r;
      sh_r     <= sum_w[2*tmk_pkg::DW-1:tmk_pkg::FRAC_BITS];
      neg3_r   <= neg2_r;
      p_r      <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tmk_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle: (|num| << FRAC_BITS) / den, given the sign of num and saturated.
module tmk_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  tmk_pkg::fx_t num,
  input  tmk_pkg::fx_t den,
  output logic         busy,
  output tmk_pkg::fx_t quo
);

  logic                          busy_r;
  logic [tmk_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [tmk_pkg::NUM_W-1:0]     nr_r, q_r;
  logic [tmk_pkg::DW-1:0]        rem_r, rem_nxt, mag_w;
  logic                          neg_r;
  tmk_pkg::fx_t                  quo_r, quo_nxt;
  logic [tmk_pkg::DW:0]          trial_w, diff_w;
  logic                          ge_w, ovf_w;

  assign mag_w   = num[tmk_pkg::DW-1] ? (~num + 1'b1) : num;
  assign trial_w = {rem_r, nr_r[tmk_pkg::NUM_W-1]};
  assign diff_w  = trial_w - {1'b0, den};
  assign ge_w    = trial_w >= {1'b0, den};
  assign rem_nxt = ge_w ? diff_w[tmk_pkg::DW-1:0] : trial_w[tmk_pkg::DW-1:0];

  always_comb begin
    if (neg_r) begin
      ovf_w = (|q_r[tmk_pkg::NUM_W-1:tmk_pkg::DW])
            || (q_r[tmk_pkg::DW-1] && (|q_r[tmk_pkg::DW-2:0]));
    end else begin
      ovf_w = |q_r[tmk_pkg::NUM_W-1:tmk_pkg::DW-1];
    end
    if (ovf_w) begin
      quo_nxt = neg_r ? tmk_pkg::SMIN : tmk_pkg::SMAX;
    end else if (neg_r) begin
      quo_nxt = -q_r[tmk_pkg::DW-1:0];
    end else begin
      quo_nxt = q_r[tmk_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= tmk_pkg::DIV_CNT_W'(tmk_pkg::NUM_W);
      nr_r   <= {mag_w, {tmk_pkg::FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
      neg_r  <= num[tmk_pkg::DW-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        nr_r  <= {nr_r[tmk_pkg::NUM_W-2:0], 1'b0};
        rem_r <= rem_nxt;
        q_r   <= {q_r[tmk_pkg::NUM_W-2:0], ge_w};
      end else begin
        quo_r  <= quo_nxt;
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tmk_step.sv =====
`default_nettype none

// One Horner step: dp = b + dp * (x + i y), with all four products in parallel.
module tmk_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  tmk_pkg::hn_t hin,
  input  tmk_pkg::fx_t b_re,
  input  tmk_pkg::fx_t b_im,
  output tmk_pkg::hn_t hout
);

  tmk_pkg::hn_t pv     [0:tmk_pkg::STEP_LAT-1];
  tmk_pkg::hn_t st_r   [1:tmk_pkg::STEP_LAT];
  tmk_pkg::hn_t st_nxt [1:tmk_pkg::STEP_LAT];
  tmk_pkg::fx_t m_xx, m_yy, m_xy, m_yx;

  tmk_mul u_mul_xx (.clk(clk), .en(en), .a(hin.dpx), .b(hin.pt.x), .p(m_xx));
  tmk_mul u_mul_yy (.clk(clk), .en(en), .a(hin.dpy), .b(hin.pt.y), .p(m_yy));
  tmk_mul u_mul_xy (.clk(clk), .en(en), .a(hin.dpx), .b(hin.pt.y), .p(m_xy));
  tmk_mul u_mul_yx (.clk(clk), .en(en), .a(hin.dpy), .b(hin.pt.x), .p(m_yx));

  always_comb begin
    pv[0] = hin;
    for (int k = 1; k < tmk_pkg::STEP_LAT; k++) begin
      pv[k] = st_r[k];
    end
  end

  always_comb begin
    for (int k = 1; k <= tmk_pkg::STEP_LAT; k++) begin
      st_nxt[k] = pv[k-1];
    end
    st_nxt[tmk_pkg::MUL_LAT+1].dpx = tmk_pkg::sat_sub(m_xx, m_yy);
    st_nxt[tmk_pkg::MUL_LAT+1].dpy = tmk_pkg::sat_add(m_xy, m_yx);
    st_nxt[tmk_pkg::MUL_LAT+2].dpx = tmk_pkg::sat_add(b_re, pv[tmk_pkg::MUL_LAT+1].dpx);
    st_nxt[tmk_pkg::MUL_LAT+2].dpy = tmk_pkg::sat_add(b_im, pv[tmk_pkg::MUL_LAT+1].dpy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= tmk_pkg::STEP_LAT; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 1; k <= tmk_pkg::STEP_LAT; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign hout = st_r[tmk_pkg::STEP_LAT];

endmodule

`default_nettype wire

// ===== hw/rtl/tmk_tail.sv =====
`default_nettype none

// Charge scaling, curvature terms, path correction and final momentum update.
module tmk_tail (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  tmk_pkg::hn_t hin,
  input  tmk_pkg::fx_t b0,
  input  tmk_pkg::fx_t b1,
  input  tmk_pkg::fx_t qx,
  input  tmk_pkg::fx_t qy,
  input  tmk_pkg::fx_t hxl,
  input  tmk_pkg::fx_t hyl,
  input  tmk_pkg::fx_t len,
  output logic         out_valid,
  output tmk_pkg::fx_t new_px,
  output tmk_pkg::fx_t new_py,
  output tmk_pkg::fx_t new_sigma
);

  tmk_pkg::tl_t tin;
  tmk_pkg::tl_t pv     [0:tmk_pkg::TAIL_LAT-1];
  tmk_pkg::tl_t st_r   [1:tmk_pkg::TAIL_LAT];
  tmk_pkg::tl_t st_nxt [1:tmk_pkg::TAIL_LAT];
  tmk_pkg::fx_t m_cx, m_cy, m_b1, m_a1, m_hx, m_hy, m_xd, m_yd;
  tmk_pkg::fx_t m_pbx, m_pay, m_t1, m_t2, m_t;
  logic         lpos;

  assign lpos = !len[tmk_pkg::DW-1] && (|len);

  always_comb begin
    tin       = '0;
    tin.valid = hin.valid;
    tin.pt    = hin.pt;
    tin.dpx   = hin.dpx;
    tin.dpy   = hin.dpy;
  end

  // Products that need only the Horner result, the particle, b0/b1 and the registers.
  tmk_mul u_mul_cx (.clk(clk), .en(en), .a(tin.pt.chi), .b(tin.dpx),      .p(m_cx));
  tmk_mul u_mul_cy (.clk(clk), .en(en), .a(tin.pt.chi), .b(tin.dpy),      .p(m_cy));
  tmk_mul u_mul_b1 (.clk(clk), .en(en), .a(tin.pt.chi), .b(b0),           .p(m_b1));
  tmk_mul u_mul_a1 (.clk(clk), .en(en), .a(tin.pt.chi), .b(b1),           .p(m_a1));
  tmk_mul u_mul_hx (.clk(clk), .en(en), .a(qx),         .b(tin.pt.x),     .p(m_hx));
  tmk_mul u_mul_hy (.clk(clk), .en(en), .a(qy),         .b(tin.pt.y),     .p(m_hy));
  tmk_mul u_mul_xd (.clk(clk), .en(en), .a(hxl),        .b(tin.pt.delta), .p(m_xd));
  tmk_mul u_mul_yd (.clk(clk), .en(en), .a(hyl),        .b(tin.pt.delta), .p(m_yd));

  tmk_mul u_mul_pbx (.clk(clk), .en(en), .a(st_r[tmk_pkg::T_P2].b1l),
                     .b(st_r[tmk_pkg::T_P2].hxx), .p(m_pbx));
  tmk_mul u_mul_pay (.clk(clk), .en(en), .a(st_r[tmk_pkg::T_P2].a1l),
                     .b(st_r[tmk_pkg::T_P2].hyy), .p(m_pay));
  tmk_mul u_mul_t1  (.clk(clk), .en(en), .a(st_r[tmk_pkg::T_P2].pt.chi),
                     .b(st_r[tmk_pkg::T_P2].dhh), .p(m_t1));
  tmk_mul u_mul_t2  (.clk(clk), .en(en), .a(st_r[tmk_pkg::T_P4].tt),
                     .b(len), .p(m_t2));
  tmk_mul u_mul_t   (.clk(clk), .en(en), .a(st_r[tmk_pkg::T_P6].tt),
                     .b(st_r[tmk_pkg::T_P6].pt.rvv), .p(m_t));

  always_comb begin
    pv[0] = tin;
    for (int k = 1; k < tmk_pkg::TAIL_LAT; k++) begin
      pv[k] = st_r[k];
    end
  end

  always_comb begin
    for (int k = 1; k <= tmk_pkg::TAIL_LAT; k++) begin
      st_nxt[k] = pv[k-1];
    end
    // Charge-scaled kick and the curvature sums.
    st_nxt[tmk_pkg::T_P2].dpx = tmk_pkg::sat_neg(m_cx);
    st_nxt[tmk_pkg::T_P2].dpy = m_cy;
    st_nxt[tmk_pkg::T_P2].ex  = tmk_pkg::sat_add(hxl, m_xd);
    st_nxt[tmk_pkg::T_P2].ey  = tmk_pkg::sat_add(hyl, m_yd);
    st_nxt[tmk_pkg::T_P2].dhh = tmk_pkg::sat_sub(m_hx, m_hy);
    st_nxt[tmk_pkg::T_P2].b1l = m_b1;
    st_nxt[tmk_pkg::T_P2].a1l = m_a1;
    st_nxt[tmk_pkg::T_P2].hxx = m_hx;
    st_nxt[tmk_pkg::T_P2].hyy = m_hy;
    // Curvature corrections to the kick.
    st_nxt[tmk_pkg::T_P4].fx  = tmk_pkg::sat_sub(pv[tmk_pkg::T_P4-1].ex, m_pbx);
    st_nxt[tmk_pkg::T_P4].fy  = tmk_pkg::sat_sub(pv[tmk_pkg::T_P4-1].ey, m_pay);
    st_nxt[tmk_pkg::T_P4].tt  = m_t1;
    // Apply the corrections only for a positive length.
    if (lpos) begin
      st_nxt[tmk_pkg::T_P6].dpx = tmk_pkg::sat_add(pv[tmk_pkg::T_P6-1].dpx,
                                                    pv[tmk_pkg::T_P6-1].fx);
      st_nxt[tmk_pkg::T_P6].dpy = tmk_pkg::sat_sub(pv[tmk_pkg::T_P6-1].dpy,
                                                    pv[tmk_pkg::T_P6-1].fy);
    end
    st_nxt[tmk_pkg::T_P6].tt  = m_t2;
    // Final momentum update and path correction.
    st_nxt[tmk_pkg::T_P8].pt.px = tmk_pkg::sat_add(pv[tmk_pkg::T_P8-1].pt.px,
                                                   pv[tmk_pkg::T_P8-1].dpx);
    st_nxt[tmk_pkg::T_P8].pt.py = tmk_pkg::sat_add(pv[tmk_pkg::T_P8-1].pt.py,
                                                   pv[tmk_pkg::T_P8-1].dpy);
    if (lpos) begin
      st_nxt[tmk_pkg::T_P8].pt.sigma = tmk_pkg::sat_sub(pv[tmk_pkg::T_P8-1].pt.sigma, m_t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= tmk_pkg::TAIL_LAT; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 1; k <= tmk_pkg::TAIL_LAT; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = st_r[tmk_pkg::TAIL_LAT].valid;
  assign new_px    = st_r[tmk_pkg::TAIL_LAT].pt.px;
  assign new_py    = st_r[tmk_pkg::TAIL_LAT].pt.py;
  assign new_sigma = st_r[tmk_pkg::TAIL_LAT].pt.sigma;

endmodule

`default_nettype wire

// ===== hw/rtl/thin_multipole_kick_unit.sv =====
// Channel   Direction  Handshake               Contents
// in_       slave      in_tvalid / in_tready   tuser: command; tdata: index, strength, particle
// out_      master     out_tvalid / out_tready tdata: new_px, new_py, new_sigma
// cfg_      write      cfg_we                  cfg_index selects a register, cfg_wdata its value
//
// A track transfer can be taken every cycle while the pipe advances and no register
// write is being worked off; it passes 16 Horner steps of 6 stages and a 20-stage tail,
// each multiply 4 stages deep. A coefficient write is taken only once no track item
// is in flight, since the store is read at fixed stages along the pipe.
// After a register write the input is held off while the two serial dividers
// recompute hxl/l and hyl/l, one quotient bit a cycle.
// Reset is synchronous and clears the store and the registers.
// While a result waits with out_tready low the whole pipe holds; nothing is dropped or repeated.
`default_nettype none

module thin_multipole_kick_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // From bit 0: coef_index, coef_value, pos_x, pos_y, mom_px, mom_py,
  // charge_ratio, energy_dev, path_sigma, velocity_ratio, zero padding.
  input  logic [tmk_pkg::IN_DW-1:0]   in_tdata,
  // Bit 0: command (0 writes a coefficient, 1 tracks a particle).
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // From bit 0: new_px, new_py, new_sigma.
  output logic [tmk_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tmk_pkg::DW-1:0]      cfg_wdata
);

  tmk_pkg::in_data_t          din;
  tmk_pkg::out_data_t         dout;
  logic [tmk_pkg::ORD_W-1:0]  ord_r, ord_eff;
  tmk_pkg::fx_t               hxl_r, hyl_r, len_r;
  logic                       pend_r;
  tmk_pkg::fx_t               coef_r [0:tmk_pkg::COEF_DEPTH-1];
  tmk_pkg::fx_t               b_re [0:tmk_pkg::NSTEP-1];
  tmk_pkg::fx_t               b_im [0:tmk_pkg::NSTEP-1];
  tmk_pkg::hn_t               chain [0:tmk_pkg::NSTEP];
  logic [tmk_pkg::INFL_W-1:0] infl_r, infl_nxt;
  logic                       adv, in_fire, trk_fire, wr_fire, out_fire;
  logic                       is_track;
  logic                       bsy_x, bsy_y;
  tmk_pkg::fx_t               qx, qy;
  logic                       tail_valid;
  tmk_pkg::fx_t               new_px, new_py, new_sigma;

  assign din      = in_tdata;
  assign is_track = (tmk_pkg::cmd_t'(in_tuser) == tmk_pkg::CMD_TRACK);

  // The whole pipe moves together whenever the output register can take a value.
  assign adv       = !tail_valid || out_tready;
  assign in_tready = adv && !pend_r && !bsy_x && !bsy_y
                   && (is_track || (infl_r == '0));
  assign in_fire   = in_tvalid && in_tready;
  assign trk_fire  = in_fire && is_track;
  assign wr_fire   = in_fire && !is_track;
  assign out_fire  = tail_valid && out_tready;

  assign infl_nxt = infl_r + tmk_pkg::INFL_W'(trk_fire) - tmk_pkg::INFL_W'(out_fire);

  // Configuration registers; pend_r, a registered copy of cfg_we, starts the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r  <= '0;
      hxl_r  <= '0;
      hyl_r  <= '0;
      len_r  <= '0;
      pend_r <= 1'b0;
      infl_r <= '0;
    end else begin
      pend_r <= cfg_we;
      infl_r <= infl_nxt;
      if (cfg_we) begin
        unique case (tmk_pkg::cfg_idx_t'(cfg_index))
          tmk_pkg::CFG_ORDER: ord_r <= cfg_wdata[tmk_pkg::ORD_W-1:0];
          tmk_pkg::CFG_HXL:   hxl_r <= cfg_wdata;
          tmk_pkg::CFG_HYL:   hyl_r <= cfg_wdata;
          tmk_pkg::CFG_LEN:   len_r <= cfg_wdata;
          default:            ord_r <= ord_r;
        endcase
      end
    end
  end

  // Coefficient store. Slot 2n holds the normal strength of order n, 2n+1 the skew.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tmk_pkg::COEF_DEPTH; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_fire && (int'(din.coef_index) < tmk_pkg::COEF_DEPTH)) begin
      coef_r[din.coef_index] <= din.coef_value;
    end
  end

  assign ord_eff = (int'(ord_r) > tmk_pkg::MAX_ORDER) ?
                   tmk_pkg::ORD_W'(tmk_pkg::MAX_ORDER) : ord_r;

  // Step g handles order MAX_ORDER - g. Orders above the configured one add zero,
  // which keeps the running value at zero until the leading term is reached.
  always_comb begin
    for (int g = 0; g < tmk_pkg::NSTEP; g++) begin
      if ((tmk_pkg::MAX_ORDER - g) <= int'(ord_eff)) begin
        b_re[g] = coef_r[2 * (tmk_pkg::MAX_ORDER - g)];
        b_im[g] = coef_r[2 * (tmk_pkg::MAX_ORDER - g) + 1];
      end else begin
        b_re[g] = '0;
        b_im[g] = '0;
      end
    end
  end

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = trk_fire;
    chain[0].pt.x     = din.pos_x;
    chain[0].pt.y     = din.pos_y;
    chain[0].pt.px    = din.mom_px;
    chain[0].pt.py    = din.mom_py;
    chain[0].pt.chi   = din.charge_ratio;
    chain[0].pt.delta = din.energy_dev;
    chain[0].pt.sigma = din.path_sigma;
    chain[0].pt.rvv   = din.velocity_ratio;
  end

  for (genvar g = 0; g < tmk_pkg::NSTEP; g++) begin : g_step
    tmk_step u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .hin  (chain[g]),
      .b_re (b_re[g]),
      .b_im (b_im[g]),
      .hout (chain[g+1])
    );
  end

  // hxl/l and hyl/l only matter for a positive length; they are always recomputed.
  tmk_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(pend_r), .num(hxl_r), .den(len_r),
    .busy(bsy_x), .quo(qx)
  );

  tmk_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(pend_r), .num(hyl_r), .den(len_r),
    .busy(bsy_y), .quo(qy)
  );

  tmk_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .hin      (chain[tmk_pkg::NSTEP]),
    .b0       (coef_r[0]),
    .b1       (coef_r[1]),
    .qx       (qx),
    .qy       (qy),
    .hxl      (hxl_r),
    .hyl      (hyl_r),
    .len      (len_r),
    .out_valid(tail_valid),
    .new_px   (new_px),
    .new_py   (new_py),
    .new_sigma(new_sigma)
  );

  assign dout.new_px    = new_px;
  assign dout.new_py    = new_py;
  assign dout.new_sigma = new_sigma;
  assign out_tdata      = dout;
  assign out_tvalid     = tail_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/tmk_checker.sv =====
`default_nettype none

module tmk_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [tmk_pkg::IN_DW-1:0]   in_tdata,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tmk_pkg::OUT_DW-1:0]  out_tdata,
  input logic                        cfg_we,
  input logic [1:0]                  cfg_index,
  input logic [tmk_pkg::DW-1:0]      cfg_wdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipe.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A coefficient write is never taken while a result waits on the output.
  a_wr_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && (tmk_pkg::cmd_t'(in_tuser) == tmk_pkg::CMD_WRITE) && out_tvalid
    |-> !in_tready)
    else $error("coefficient write taken with results pending");

  // Input is held off while the curvature quotients are recomputed.
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken right after a register write");

endmodule

bind thin_multipole_kick_unit tmk_checker u_tmk_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
module tb;

  // Cycles without any transfer or register write before the run is declared hung.
  // The slowest legal gap is the register hold-off plus a full pipe plus a stall.
  localparam int HANG_LIMIT = 4000;
  // Cycles to let the pipe settle before a register write, mid-phase and at the end.
  localparam int SETTLE = tmk_pkg::TOTAL_LAT + 16;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [tmk_pkg::IN_DW-1:0]    in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [tmk_pkg::OUT_DW-1:0]   out_tdata;
  logic                         cfg_we;
  logic [1:0]                   cfg_index;
  logic [tmk_pkg::DW-1:0]       cfg_wdata;

  thin_multipole_kick_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the coefficient store and the registers, kept in step with
  // every accepted coefficient write and every register write.
  tmk_pkg::fx_t        coef_mem [tmk_pkg::COEF_DEPTH];
  logic [3:0]          sh_order;
  tmk_pkg::fx_t        sh_hxl;
  tmk_pkg::fx_t        sh_hyl;
  tmk_pkg::fx_t        sh_len;

  // Kicks that have been predicted but not yet seen on the output, oldest first.
  tmk_pkg::out_data_t  kick_q [$];
  int                  mismatches;
  bit                  no_idle;
  int                  hang_cnt;
  int                  stall_left;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the predictor. Magnitudes are worked out in 128
  // bits and saturated back to the signed 64-bit range.
  // ---------------------------------------------------------------------------
  function automatic tmk_pkg::fx_t clip_mag(logic [127:0] m, logic neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) return tmk_pkg::SMIN;
      return tmk_pkg::fx_t'(64'd0 - m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return tmk_pkg::SMAX;
    return tmk_pkg::fx_t'(m[63:0]);
  endfunction

  function automatic logic [63:0] abs_u(tmk_pkg::fx_t v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // Product rounded to nearest, ties away from zero.
  function automatic tmk_pkg::fx_t qmul(tmk_pkg::fx_t a, tmk_pkg::fx_t b);
    logic [127:0] p;
    p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
    p = (p + (128'd1 << (tmk_pkg::FRAC_BITS - 1))) >> tmk_pkg::FRAC_BITS;
    return clip_mag(p, a[63] != b[63]);
  endfunction

  // Quotient truncated toward zero; the divisor is always positive here.
  function automatic tmk_pkg::fx_t qdiv(tmk_pkg::fx_t n, tmk_pkg::fx_t d);
    logic [127:0] num;
    num = {64'd0, abs_u(n)} << tmk_pkg::FRAC_BITS;
    return clip_mag(num / {64'd0, d}, n[63]);
  endfunction

  function automatic tmk_pkg::fx_t qadd(tmk_pkg::fx_t a, tmk_pkg::fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return tmk_pkg::SMAX;
    if (s < -65'sh0_8000_0000_0000_0000) return tmk_pkg::SMIN;
    return s[63:0];
  endfunction

  function automatic tmk_pkg::fx_t qsub(tmk_pkg::fx_t a, tmk_pkg::fx_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return tmk_pkg::SMAX;
    if (s < -65'sh0_8000_0000_0000_0000) return tmk_pkg::SMIN;
    return s[63:0];
  endfunction

  // Expected kick for one particle under the current store and registers.
  function automatic tmk_pkg::out_data_t kick_of(tmk_pkg::in_data_t d);
    tmk_pkg::out_data_t r;
    tmk_pkg::fx_t       dpx, dpy, zre, zim, b1l, a1l, hxx, hyy, tt;
    int                 ord;
    ord = int'(sh_order);
    if (ord > tmk_pkg::MAX_ORDER) ord = tmk_pkg::MAX_ORDER;
    dpx = coef_mem[2 * ord];
    dpy = coef_mem[2 * ord + 1];
    for (int i = ord - 1; i >= 0; i--) begin
      zre = qsub(qmul(dpx, d.pos_x), qmul(dpy, d.pos_y));
      zim = qadd(qmul(dpx, d.pos_y), qmul(dpy, d.pos_x));
      dpx = qadd(coef_mem[2 * i], zre);
      dpy = qadd(coef_mem[2 * i + 1], zim);
    end
    dpx = qmul(d.charge_ratio, dpx);
    dpx = (dpx == tmk_pkg::SMIN) ? tmk_pkg::SMAX : -dpx;
    dpy = qmul(d.charge_ratio, dpy);
    r.new_sigma = d.path_sigma;
    // Curvature terms only for a positive length.
    if (sh_len > 0) begin
      b1l = qmul(d.charge_ratio, coef_mem[0]);
      a1l = qmul(d.charge_ratio, coef_mem[1]);
      hxx = qmul(qdiv(sh_hxl, sh_len), d.pos_x);
      hyy = qmul(qdiv(sh_hyl, sh_len), d.pos_y);
      dpx = qadd(dpx, qsub(qadd(sh_hxl, qmul(sh_hxl, d.energy_dev)), qmul(b1l, hxx)));
      dpy = qsub(dpy, qsub(qadd(sh_hyl, qmul(sh_hyl, d.energy_dev)), qmul(a1l, hyy)));
      tt = qmul(qmul(qmul(d.charge_ratio, qsub(hxx, hyy)), sh_len), d.velocity_ratio);
      r.new_sigma = qsub(d.path_sigma, tt);
    end
    r.new_px = qadd(d.mom_px, dpx);
    r.new_py = qadd(d.mom_py, dpy);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // A value that is mostly of moderate size so the polynomial stays in range,
  // with full-range values and the range ends mixed in.
  function automatic tmk_pkg::fx_t any_fx();
    tmk_pkg::fx_t v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 4))
          0: v = tmk_pkg::SMIN;
          1: v = tmk_pkg::SMAX;
          2: v = '0;
          3: v = -1;
          default: v = tmk_pkg::fx_t'(1) << tmk_pkg::FRAC_BITS;
        endcase
      end
      default: v = $signed({$urandom, $urandom}) >>> $urandom_range(12, 30);
    endcase
    return v;
  endfunction

  function automatic tmk_pkg::in_data_t any_particle();
    tmk_pkg::in_data_t d;
    d.pad            = '0;
    d.coef_index     = 5'($urandom);
    d.coef_value     = {$urandom, $urandom};
    d.pos_x          = any_fx();
    d.pos_y          = any_fx();
    d.mom_px         = any_fx();
    d.mom_py         = any_fx();
    d.charge_ratio   = any_fx();
    d.energy_dev     = any_fx();
    d.path_sigma     = any_fx();
    d.velocity_ratio = any_fx();
    return d;
  endfunction

  // Offers one item after a random gap and returns at the edge that takes it.
  // The prediction is made at that edge, so the shadow store follows the
  // order in which the block sees the transfers.
  task automatic send_item(tmk_pkg::cmd_t cmd, tmk_pkg::in_data_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    // Ready only moves at rising edges, so it is stable at the falling edge.
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (cmd == tmk_pkg::CMD_WRITE) coef_mem[d.coef_index] = d.coef_value;
    else kick_q.push_back(kick_of(d));
  endtask

  task automatic write_coef(logic [4:0] idx, tmk_pkg::fx_t v);
    tmk_pkg::in_data_t d;
    d = any_particle();
    d.coef_index = idx;
    d.coef_value = v;
    send_item(tmk_pkg::CMD_WRITE, d);
  endtask

  // Drops valid and waits until every predicted kick has come out, then lets
  // the pipe run empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (kick_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(tmk_pkg::cfg_idx_t idx, tmk_pkg::fx_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      tmk_pkg::CFG_ORDER: sh_order = v[3:0];
      tmk_pkg::CFG_HXL:   sh_hxl   = v;
      tmk_pkg::CFG_HYL:   sh_hyl   = v;
      tmk_pkg::CFG_LEN:   sh_len   = v;
    endcase
  endtask

  task automatic set_regs(logic [3:0] ord, tmk_pkg::fx_t hxl, tmk_pkg::fx_t hyl,
                          tmk_pkg::fx_t len);
    write_reg(tmk_pkg::CFG_ORDER, {$urandom, 15'($urandom_range(0, 15'h7FFF)), 13'd0, ord});
    write_reg(tmk_pkg::CFG_HXL, hxl);
    write_reg(tmk_pkg::CFG_HYL, hyl);
    write_reg(tmk_pkg::CFG_LEN, len);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Range ends of every field, both commands, order zero and the top order,
  // and a zero, negative and positive length.
  task automatic test_directed();
    tmk_pkg::in_data_t d;
    tmk_pkg::fx_t      one;
    one = tmk_pkg::fx_t'(1) << tmk_pkg::FRAC_BITS;
    // Cleared store with order zero: the momenta pass through unchanged.
    d = any_particle();
    send_item(tmk_pkg::CMD_TRACK, d);
    write_coef(5'd0, tmk_pkg::SMAX);
    write_coef(5'd1, tmk_pkg::SMIN);
    write_coef(5'd31, tmk_pkg::SMAX);
    write_coef(5'd30, tmk_pkg::SMIN);
    d.pos_x = tmk_pkg::SMAX; d.pos_y = tmk_pkg::SMIN; d.charge_ratio = tmk_pkg::SMIN;
    d.mom_px = tmk_pkg::SMAX; d.mom_py = tmk_pkg::SMIN;
    send_item(tmk_pkg::CMD_TRACK, d);
    d.charge_ratio = tmk_pkg::SMAX; d.mom_px = tmk_pkg::SMIN; d.mom_py = tmk_pkg::SMAX;
    send_item(tmk_pkg::CMD_TRACK, d);
    // Top order with the extreme top coefficients.
    set_regs(4'd15, one, -one, -one);
    d = any_particle();
    d.pos_x = tmk_pkg::SMIN; d.pos_y = tmk_pkg::SMAX;
    send_item(tmk_pkg::CMD_TRACK, d);
    d.pos_x = one; d.pos_y = -one; d.charge_ratio = one;
    send_item(tmk_pkg::CMD_TRACK, d);
    // Positive length: curvature terms and the path correction.
    set_regs(4'd1, tmk_pkg::SMAX, tmk_pkg::SMIN, one);
    d = any_particle();
    d.energy_dev = tmk_pkg::SMAX; d.velocity_ratio = tmk_pkg::SMIN;
    d.path_sigma = tmk_pkg::SMAX;
    send_item(tmk_pkg::CMD_TRACK, d);
    d.energy_dev = tmk_pkg::SMIN; d.velocity_ratio = tmk_pkg::SMAX;
    d.path_sigma = tmk_pkg::SMIN;
    send_item(tmk_pkg::CMD_TRACK, d);
    write_reg(tmk_pkg::CFG_LEN, tmk_pkg::SMAX);
    send_item(tmk_pkg::CMD_TRACK, any_particle());
    write_reg(tmk_pkg::CFG_LEN, tmk_pkg::fx_t'(1));
    send_item(tmk_pkg::CMD_TRACK, any_particle());
    write_reg(tmk_pkg::CFG_LEN, tmk_pkg::SMIN);
    send_item(tmk_pkg::CMD_TRACK, any_particle());
    write_reg(tmk_pkg::CFG_LEN, '0);
    send_item(tmk_pkg::CMD_TRACK, any_particle());
  endtask

  // One random phase: a register setting, a fresh set of coefficients, then a
  // stream that is mostly tracking with a few coefficient rewrites mixed in.
  task automatic test_random_phase(int n_items, bit hold_mid);
    logic [3:0]   ord;
    tmk_pkg::fx_t len;
    ord = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: len = '0;
      1: len = -any_fx();
      default: len = tmk_pkg::fx_t'($urandom_range(1, 64)) << ($urandom_range(40, 52));
    endcase
    set_regs(ord, any_fx(), any_fx(), len);
    for (int i = 0; i <= int'(ord) && i < 16; i++) begin
      write_coef(5'(2 * i), $signed({$urandom, $urandom}) >>> $urandom_range(14, 24));
      write_coef(5'(2 * i + 1), $signed({$urandom, $urandom}) >>> $urandom_range(14, 24));
    end
    for (int k = 0; k < n_items; k++) begin
      if (hold_mid && k == n_items / 2) drain();
      if ($urandom_range(0, 19) == 0) write_coef(5'($urandom), any_fx());
      else send_item(tmk_pkg::CMD_TRACK, any_particle());
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      // Every third phase runs back to back on both sides.
      no_idle = (p % 3 == 2);
      test_random_phase(158, p == 3);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tmk_pkg::out_data_t got;
    tmk_pkg::out_data_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (kick_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = kick_q.pop_front();
          if (got.new_px !== want.new_px) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_px: expected %h, actual %h", want.new_px, got.new_px);
          end
          if (got.new_py !== want.new_py) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_py: expected %h, actual %h", want.new_py, got.new_py);
          end
          if (got.new_sigma !== want.new_sigma) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_sigma: expected %h, actual %h", want.new_sigma, got.new_sigma);
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hang detection: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n) begin
      hang_cnt <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    for (int i = 0; i < tmk_pkg::COEF_DEPTH; i++) coef_mem[i] = '0;
    sh_order = '0;
    sh_hxl   = '0;
    sh_hyl   = '0;
    sh_len   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();

    // Wait for the last kicks, then make sure nothing extra comes out.
    drain();
    if (mismatches == 0 && kick_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
